// ----- src/ihc_pkg.sv -----
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants of the IPv4 header checker: result codes,
// payload kinds, header byte positions and the last-byte snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

package ihc_pkg;

  localparam int unsigned CountW = 17;
  localparam int unsigned SumW   = 21;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  localparam logic [3:0] VERSION_V4 = 4'd4;
  localparam logic [3:0] VERSION_V6 = 4'd6;
  localparam logic [3:0] IHL_MIN    = 4'd5;

  localparam logic [CountW-1:0] POS_VER_IHL   = 17'd0;
  localparam logic [CountW-1:0] POS_LEN_HI    = 17'd2;
  localparam logic [CountW-1:0] POS_LEN_LO    = 17'd3;
  localparam logic [CountW-1:0] POS_IDENT_HI  = 17'd4;
  localparam logic [CountW-1:0] POS_IDENT_LO  = 17'd5;
  localparam logic [CountW-1:0] POS_FRAG_HI   = 17'd6;
  localparam logic [CountW-1:0] POS_FRAG_LO   = 17'd7;
  localparam logic [CountW-1:0] POS_PROTO     = 17'd9;
  localparam logic [CountW-1:0] POS_SRC_FIRST = 17'd12;
  localparam logic [CountW-1:0] POS_DST_FIRST = 17'd16;
  localparam logic [CountW-1:0] MIN_HEADER    = 17'd20;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [15:0] CSUM_GOOD = 16'hffff;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_NOT_IP          = 3'd1,
    ST_IPV6            = 3'd2,
    ST_TOO_SMALL       = 3'd3,
    ST_TRUNCATED       = 3'd4,
    ST_BAD_IHL         = 3'd5,
    ST_BAD_CSUM        = 3'd6,
    ST_PROTO_UNHANDLED = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_TCP  = 2'd0,
    KIND_UDP  = 2'd1,
    KIND_ICMP = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [3:0]        version;
    logic [3:0]        ihl;
    logic [CountW-1:0] count;
    logic [15:0]       length;
    logic [15:0]       ident;
    logic              more_frag;
    logic [12:0]       offset;
    logic [7:0]        proto;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [SumW-1:0]   sum;
  } snap_t;

  typedef struct packed {
    status_t     status;
    kind_t       payload_kind;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] ident;
    logic        more_fragments;
    logic [15:0] fragment_offset_bytes;
    logic [5:0]  header_bytes;
    logic [15:0] total_length;
  } res_t;

endpackage

`default_nettype wire

// ----- src/ihc_in_if.sv -----
// ----------------------------------------------------------------------------
// ihc_in_if
// Byte stream channel: one packet byte per item with a last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- src/ihc_out_if.sv -----
// ----------------------------------------------------------------------------
// ihc_out_if
// Result channel: one header check result per packet.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  payload_kind;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] ident;
  logic        more_fragments;
  logic [15:0] fragment_offset_bytes;
  logic [5:0]  header_bytes;
  logic [15:0] total_length;

  modport source (
    output valid, output status, output payload_kind, output protocol_number,
    output source_address, output dest_address, output ident,
    output more_fragments, output fragment_offset_bytes, output header_bytes,
    output total_length, input ready
  );
  modport sink (
    input valid, input status, input payload_kind, input protocol_number,
    input source_address, input dest_address, input ident,
    input more_fragments, input fragment_offset_bytes, input header_bytes,
    input total_length, output ready
  );
endinterface

`default_nettype wire

// ----- src/ipv4_header_checker.sv -----
// ----------------------------------------------------------------------------
// ipv4_header_checker
// Streaming IPv4 header checker: captures header fields, keeps the
// ones-complement header sum, and gives one result per packet.
// ----------------------------------------------------------------------------
//  channel  dir  item                         handshake
//  pkt      in   data_byte, last_byte         valid/ready
//  res      out  status, kind, header fields  valid/ready
//
//  One byte is taken per cycle unless pkt stalls; the running sum and
//  counter update each byte. A last byte is snapshotted, checked in the
//  next stage, and registered into the output register that drives res.
//  A stalled result holds in the output register while a later packet
//  streams on; pkt stalls only when both the snapshot and output stages hold.
//  Synchronous reset clears the packet state and both stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  ihc_in_if.sink     pkt,
  ihc_out_if.source  res
);
  import ihc_pkg::*;

  logic [CountW-1:0] byte_count, byte_count_next;
  logic [3:0]        version_nibble, version_nibble_next;
  logic [3:0]        ihl_words, ihl_words_next;
  logic [15:0]       length_field, length_field_next;
  logic [15:0]       ident_reg, ident_reg_next;
  logic              more_frag, more_frag_next;
  logic [12:0]       offset_field, offset_field_next;
  logic [7:0]        proto_reg, proto_reg_next;
  logic [31:0]       src_reg, src_reg_next;
  logic [31:0]       dst_reg, dst_reg_next;
  logic [SumW-1:0]   sum_acc, sum_acc_next;
  logic [7:0]        pending_high, pending_high_next;

  logic [7:0]        b;
  logic [5:0]        hdr_cur;
  logic              in_hdr;
  logic              accept;

  snap_t             snap;
  logic              snap_valid;
  res_t              res_q, res_next;
  logic              res_valid;
  logic              out_free;

  logic [5:0]        snap_hdr;
  logic [16:0]       fold1;
  logic [15:0]       fold2;

  assign b        = pkt.data_byte;
  assign out_free = !res_valid || res.ready;
  assign pkt.ready = !snap_valid || out_free;
  assign accept   = pkt.valid && pkt.ready;

  always_comb begin
    version_nibble_next = version_nibble;
    ihl_words_next      = ihl_words;
    length_field_next   = length_field;
    ident_reg_next      = ident_reg;
    more_frag_next      = more_frag;
    offset_field_next   = offset_field;
    proto_reg_next      = proto_reg;
    src_reg_next        = src_reg;
    dst_reg_next        = dst_reg;
    sum_acc_next        = sum_acc;
    pending_high_next   = pending_high;

    unique case (byte_count)
      POS_VER_IHL: begin
        version_nibble_next = b[7:4];
        ihl_words_next      = b[3:0];
      end
      POS_LEN_HI:   length_field_next = {b, length_field[7:0]};
      POS_LEN_LO:   length_field_next = {length_field[15:8], b};
      POS_IDENT_HI: ident_reg_next    = {b, ident_reg[7:0]};
      POS_IDENT_LO: ident_reg_next    = {ident_reg[15:8], b};
      POS_FRAG_HI: begin
        more_frag_next    = b[5];
        offset_field_next = {b[4:0], offset_field[7:0]};
      end
      POS_FRAG_LO:  offset_field_next = {offset_field[12:8], b};
      POS_PROTO:    proto_reg_next    = b;
      default: ;
    endcase

    if (byte_count >= POS_SRC_FIRST && byte_count < POS_DST_FIRST) begin
      src_reg_next = {src_reg[23:0], b};
    end else if (byte_count >= POS_DST_FIRST && byte_count < MIN_HEADER) begin
      dst_reg_next = {dst_reg[23:0], b};
    end

    hdr_cur = {ihl_words_next, 2'b00};
    in_hdr  = byte_count < {{(CountW-6){1'b0}}, hdr_cur};
    if (in_hdr) begin
      if (!byte_count[0]) begin
        pending_high_next = b;
      end else begin
        sum_acc_next = sum_acc + {{(SumW-16){1'b0}}, pending_high, b};
      end
    end

    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : byte_count;
  end

  // packet state: advance per byte, clear after the last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && pkt.last_byte)) begin
      byte_count     <= '0;
      version_nibble <= '0;
      ihl_words      <= '0;
      length_field   <= '0;
      ident_reg      <= '0;
      more_frag      <= 1'b0;
      offset_field   <= '0;
      proto_reg      <= '0;
      src_reg        <= '0;
      dst_reg        <= '0;
      sum_acc        <= '0;
      pending_high   <= '0;
    end else if (accept) begin
      byte_count     <= byte_count_next;
      version_nibble <= version_nibble_next;
      ihl_words      <= ihl_words_next;
      length_field   <= length_field_next;
      ident_reg      <= ident_reg_next;
      more_frag      <= more_frag_next;
      offset_field   <= offset_field_next;
      proto_reg      <= proto_reg_next;
      src_reg        <= src_reg_next;
      dst_reg        <= dst_reg_next;
      sum_acc        <= sum_acc_next;
      pending_high   <= pending_high_next;
    end
  end

  // snapshot stage
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && pkt.last_byte) begin
      snap_valid <= 1'b1;
    end else if (out_free) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pkt.last_byte) begin
      snap.version   <= version_nibble_next;
      snap.ihl       <= ihl_words_next;
      snap.count     <= byte_count_next;
      snap.length    <= length_field_next;
      snap.ident     <= ident_reg_next;
      snap.more_frag <= more_frag_next;
      snap.offset    <= offset_field_next;
      snap.proto     <= proto_reg_next;
      snap.src       <= src_reg_next;
      snap.dst       <= dst_reg_next;
      snap.sum       <= sum_acc_next;
    end
  end

  // check stage
  always_comb begin
    snap_hdr = {snap.ihl, 2'b00};
    fold1    = {1'b0, snap.sum[15:0]} + {{(17-(SumW-16)){1'b0}}, snap.sum[SumW-1:16]};
    fold2    = fold1[15:0] + {15'b0, fold1[16]};

    res_next.payload_kind = KIND_NONE;
    if (snap.version == VERSION_V6) begin
      res_next.status = ST_IPV6;
    end else if (snap.version != VERSION_V4) begin
      res_next.status = ST_NOT_IP;
    end else if (snap.count < MIN_HEADER) begin
      res_next.status = ST_TOO_SMALL;
    end else if (snap.count < {1'b0, snap.length}) begin
      res_next.status = ST_TRUNCATED;
    end else if (snap.ihl < IHL_MIN ||
                 snap.count < {{(CountW-6){1'b0}}, snap_hdr}) begin
      res_next.status = ST_BAD_IHL;
    end else if (fold2 != CSUM_GOOD) begin
      res_next.status = ST_BAD_CSUM;
    end else if (snap.proto == PROTO_TCP) begin
      res_next.status       = ST_OK;
      res_next.payload_kind = KIND_TCP;
    end else if (snap.proto == PROTO_UDP) begin
      res_next.status       = ST_OK;
      res_next.payload_kind = KIND_UDP;
    end else if (snap.proto == PROTO_ICMP) begin
      res_next.status       = ST_OK;
      res_next.payload_kind = KIND_ICMP;
    end else begin
      res_next.status = ST_PROTO_UNHANDLED;
    end

    res_next.protocol_number       = snap.proto;
    res_next.source_address        = snap.src;
    res_next.dest_address          = snap.dst;
    res_next.ident                 = snap.ident;
    res_next.more_fragments        = snap.more_frag;
    res_next.fragment_offset_bytes = {snap.offset, 3'b000};
    res_next.header_bytes          = snap_hdr;
    res_next.total_length          = snap.length;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      res_q <= res_next;
    end
  end

  assign res.valid                 = res_valid;
  assign res.status                = res_q.status;
  assign res.payload_kind          = res_q.payload_kind;
  assign res.protocol_number       = res_q.protocol_number;
  assign res.source_address        = res_q.source_address;
  assign res.dest_address          = res_q.dest_address;
  assign res.ident                 = res_q.ident;
  assign res.more_fragments        = res_q.more_fragments;
  assign res.fragment_offset_bytes = res_q.fragment_offset_bytes;
  assign res.header_bytes          = res_q.header_bytes;
  assign res.total_length          = res_q.total_length;

endmodule

`default_nettype wire

// ----- src/ihc_checker.sv -----
// ----------------------------------------------------------------------------
// ihc_checker
// Port-level assertions for the IPv4 header checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ihc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [1:0]  payload_kind,
  input wire logic [7:0]  protocol_number,
  input wire logic [31:0] source_address,
  input wire logic [5:0]  header_bytes
);
  import ihc_pkg::*;

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(payload_kind) && $stable(source_address))
    else $error("stalled result changed");

  a_kind_iff_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_OK) == (payload_kind != KIND_NONE)))
    else $error("payload kind disagrees with status");

  a_ok_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> header_bytes >= 6'(MIN_HEADER))
    else $error("ok status with short header");

  a_kind_proto: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (payload_kind != KIND_TCP || protocol_number == PROTO_TCP) &&
      (payload_kind != KIND_UDP || protocol_number == PROTO_UDP) &&
      (payload_kind != KIND_ICMP || protocol_number == PROTO_ICMP))
    else $error("payload kind disagrees with protocol");

endmodule

bind ipv4_header_checker ihc_checker u_ihc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (res.valid),
  .out_ready       (res.ready),
  .status          (res.status),
  .payload_kind    (res.payload_kind),
  .protocol_number (res.protocol_number),
  .source_address  (res.source_address),
  .header_bytes    (res.header_bytes)
);

`default_nettype wire
